[design/csph_pkg.sv]
// ----------------------------------------------------------------------------
// csph_pkg
// Shared widths, constants and datapath helpers for the cartesian to
// spherical conversion pipeline.
// ----------------------------------------------------------------------------
package csph_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_STEPS = 16;

    // Coordinates enter the CORDIC datapath scaled by 2^GUARD_BITS
    localparam int GUARD_BITS = 60 - COORD_WIDTH;
    localparam int DW         = COORD_WIDTH + GUARD_BITS + 2;

    // Angle accumulator in units of pi/2^31
    localparam int ACC_W      = 33;
    localparam int ACC_FRAC   = 16;
    localparam int ROUND_HALF = 1 << (ACC_FRAC - 1);
    localparam int RND_W      = ACC_W + 1 - ACC_FRAC;
    localparam logic signed [ACC_W-1:0] ACC_PI = 33'sh0_8000_0000;

    // Result fields
    localparam int RAD_W     = 16;
    localparam int POLAR_W   = 16;
    localparam int AZ_W      = 17;
    localparam int RAD_MAX   = (1 << RAD_W) - 1;
    localparam int POLAR_MAX = 32768;
    localparam int AZ_MIN    = -32767;
    localparam int AZ_MAX    = 32768;

    // Radius square root
    localparam int SQ_W   = 2 * COORD_WIDTH - 1;
    localparam int SUM_W  = 2 * COORD_WIDTH;
    localparam int ROOT_W = COORD_WIDTH;
    localparam int REM_W  = COORD_WIDTH + 1;

    // Removal of the CORDIC gain: multiply by 1/K in Q30
    localparam int GAIN_W    = 30;
    localparam int GAIN_FRAC = 30;
    localparam int GAIN_HALF = 1 << (GAIN_FRAC - 1);
    localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
    localparam int LO_W      = 32;
    localparam int HI_W      = DW - LO_W;
    localparam int HI_PROD_W = HI_W + GAIN_W;
    localparam int LO_PROD_W = LO_W + GAIN_W;

    // Stage 0 prepare, ANGLE_STEPS xy stages, gain multiply, gain sum,
    // z prepare, ANGLE_STEPS polar stages, output stage
    localparam int PIPE_DEPTH = 2 * ANGLE_STEPS + 5;

    localparam int IN_TDATA_W  = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RAD_W + POLAR_W + AZ_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [DW-1:0]    a;
        logic signed [DW-1:0]    b;
        logic signed [ACC_W-1:0] acc;
    } cordic_t;

    // atan(2^-i) in units of pi/2^31, rounded to nearest
    function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
        logic [31:0] e;
        case (idx)
            0:  e = 32'h2000_0000;
            1:  e = 32'h12E4_051E;
            2:  e = 32'h09FB_385B;
            3:  e = 32'h0511_11D4;
            4:  e = 32'h028B_0D43;
            5:  e = 32'h0145_D7E1;
            6:  e = 32'h00A2_F61E;
            7:  e = 32'h0051_7C55;
            8:  e = 32'h0028_BE53;
            9:  e = 32'h0014_5F2F;
            10: e = 32'h000A_2F98;
            11: e = 32'h0005_17CC;
            12: e = 32'h0002_8BE6;
            13: e = 32'h0001_45F3;
            14: e = 32'h0000_A2FA;
            15: e = 32'h0000_517D;
            16: e = 32'h0000_28BE;
            17: e = 32'h0000_145F;
            18: e = 32'h0000_0A30;
            19: e = 32'h0000_0518;
            20: e = 32'h0000_028C;
            21: e = 32'h0000_0146;
            22: e = 32'h0000_00A3;
            23: e = 32'h0000_0051;
            24: e = 32'h0000_0029;
            25: e = 32'h0000_0014;
            26: e = 32'h0000_000A;
            27: e = 32'h0000_0005;
            28: e = 32'h0000_0003;
            29: e = 32'h0000_0001;
            30: e = 32'h0000_0001;
            default: e = 32'h0000_0000;
        endcase
        return ACC_W'(e);
    endfunction

    function automatic logic signed [DW-1:0] scale_coord(
        input logic signed [COORD_WIDTH-1:0] v
    );
        logic signed [DW-1:0] w;
        w = DW'(v);
        return w <<< GUARD_BITS;
    endfunction

    // Fold the left half plane onto the right one before vectoring
    function automatic cordic_t cordic_start(
        input logic signed [DW-1:0] a,
        input logic signed [DW-1:0] b
    );
        cordic_t r;
        if (a[DW-1]) begin
            r.acc = b[DW-1] ? -ACC_PI : ACC_PI;
            r.a   = -a;
            r.b   = -b;
        end else begin
            r.acc = '0;
            r.a   = a;
            r.b   = b;
        end
        return r;
    endfunction

    // One vectoring micro-rotation, driving b towards zero
    function automatic cordic_t cordic_step(input cordic_t c, input int idx);
        logic signed [DW-1:0] da;
        logic signed [DW-1:0] db;
        cordic_t r;
        da = $signed(c.b) >>> idx;
        db = $signed(c.a) >>> idx;
        if (!c.b[DW-1]) begin
            r.a   = c.a + da;
            r.b   = c.b - db;
            r.acc = c.acc + atan_entry(idx);
        end else begin
            r.a   = c.a - da;
            r.b   = c.b + db;
            r.acc = c.acc - atan_entry(idx);
        end
        return r;
    endfunction

    // Round to pi/32768 units, ties towards +infinity
    function automatic logic signed [RND_W-1:0] acc_to_lsb(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W:0] s;
        s = (ACC_W + 1)'(acc) + (ACC_W + 1)'(ROUND_HALF);
        return RND_W'(s >>> ACC_FRAC);
    endfunction

endpackage

[design/cartesian_to_spherical_unit.sv]
// ----------------------------------------------------------------------------
// cartesian_to_spherical_unit
// Converts signed (x, y, z) into radius, polar angle and azimuth.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream s_*: one request per coordinate triple in s_tdata.
//   Master stream m_*: one result per request, in request order. Angles are
//   in units of pi/32768; the radius is rounded to nearest.
//   Datapath: two chained 16-stage CORDIC vectoring passes plus gain removal.
//   Throughput: one request per cycle, sustained while m_tready stays high.
//   The square root of the radius runs alongside the first CORDIC pass, one
//   result bit per stage.
//   Stall: a one-entry skid register behind the output stage catches the
//   result that m_tready refuses; while it is full the whole pipeline holds
//   and s_tready is low, so nothing is dropped or repeated.
//   Reset (aresetn low at a clock edge) empties the pipeline and the skid
//   register; data registers are not cleared.
//   On the z axis the azimuth is 0 and the polar angle is 0 or pi by the
//   sign of z; at the origin all three outputs are 0.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] coord_x, [31:16] coord_y, [47:32] coord_z
    input  logic [csph_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] radius, [31:16] polar_angle, [48:32] azimuth, rest zero
    output logic [csph_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import csph_pkg::*;

    localparam int D       = PIPE_DEPTH;
    localparam int N       = ANGLE_STEPS;
    localparam int GAIN_ST = N + 1;
    localparam int RHO_ST  = N + 2;
    localparam int PRE2_ST = N + 3;
    localparam int OUT_ST  = D - 1;
    localparam int RAD_ST  = COORD_WIDTH + 2;

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    logic [D-1:0]             valid_reg;
    logic                     adv;
    logic                     hold_valid_reg;
    logic [OUT_TDATA_W-1:0]   hold_word_reg;
    logic [OUT_TDATA_W-1:0]   pipe_word;

    assign adv      = !hold_valid_reg;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[D-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (hold_valid_reg) begin
            if (m_tready) begin
                hold_valid_reg <= 1'b0;
            end
        end else if (valid_reg[OUT_ST] && !m_tready) begin
            hold_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!hold_valid_reg) begin
            hold_word_reg <= pipe_word;
        end
    end

    assign m_tvalid = hold_valid_reg || valid_reg[OUT_ST];
    assign m_tdata  = hold_valid_reg ? hold_word_reg : pipe_word;

    // ------------------------------------------------------------------
    // Stage 0: unpack, squares, fold of the xy vector
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    logic signed [SQ_W-1:0]        prod_x;
    logic signed [SQ_W-1:0]        prod_y;
    logic signed [SQ_W-1:0]        prod_z;

    assign coord_x = s_tdata[COORD_WIDTH-1:0];
    assign coord_y = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign coord_z = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
    // a square never exceeds 2^30, so SQ_W bits hold it as an unsigned value
    assign prod_x  = SQ_W'(coord_x) * SQ_W'(coord_x);
    assign prod_y  = SQ_W'(coord_y) * SQ_W'(coord_y);
    assign prod_z  = SQ_W'(coord_z) * SQ_W'(coord_z);

    logic [SQ_W-1:0]                sqx_reg;
    logic [SQ_W-1:0]                sqy_reg;
    logic [SQ_W-1:0]                sqz_reg;
    logic                           axis_reg [0:D-2];
    logic                           zneg_reg [0:D-2];
    logic signed [COORD_WIDTH-1:0]  z_reg    [0:RHO_ST];
    cordic_t                        c1_reg   [0:N];

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqx_reg     <= prod_x;
            sqy_reg     <= prod_y;
            sqz_reg     <= prod_z;
            axis_reg[0] <= (coord_x == '0) && (coord_y == '0);
            zneg_reg[0] <= coord_z[COORD_WIDTH-1];
            z_reg[0]    <= coord_z;
            c1_reg[0]   <= cordic_start(scale_coord(coord_x), scale_coord(coord_y));
        end
    end

    for (genvar k = 1; k <= D - 2; k++) begin : g_flags
        always_ff @(posedge aclk) begin
            if (adv) begin
                axis_reg[k] <= axis_reg[k-1];
                zneg_reg[k] <= zneg_reg[k-1];
            end
        end
    end

    for (genvar k = 1; k <= RHO_ST; k++) begin : g_zpipe
        always_ff @(posedge aclk) begin
            if (adv) begin
                z_reg[k] <= z_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Radius: sum of squares, then one root bit per stage
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]   rad_sum_reg  [1:COORD_WIDTH];
    logic [REM_W-1:0]   rad_rem_reg  [2:COORD_WIDTH+1];
    logic [ROOT_W-1:0]  rad_root_reg [2:COORD_WIDTH+1];
    logic [RAD_W-1:0]   rad_val_reg  [RAD_ST:D-2];

    always_ff @(posedge aclk) begin
        if (adv) begin
            rad_sum_reg[1] <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
        end
    end

    for (genvar k = 2; k <= COORD_WIDTH; k++) begin : g_sum_pipe
        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_sum_reg[k] <= rad_sum_reg[k-1];
            end
        end
    end

    for (genvar k = 2; k <= COORD_WIDTH + 1; k++) begin : g_sqrt
        logic [REM_W-1:0]   rem_in;
        logic [ROOT_W-1:0]  root_in;
        logic [REM_W+1:0]   cand;
        logic [REM_W+1:0]   trial;
        logic               take;
        logic [REM_W-1:0]   rem_next;
        logic [ROOT_W-1:0]  root_next;

        if (k == 2) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = rad_rem_reg[k-1];
            assign root_in = rad_root_reg[k-1];
        end

        assign cand      = {rem_in, rad_sum_reg[k-1][SUM_W-1-2*(k-2) -: 2]};
        assign trial     = (REM_W + 2)'({root_in, 2'b01});
        assign take      = (cand >= trial);
        assign rem_next  = take ? REM_W'(cand - trial) : REM_W'(cand);
        assign root_next = {root_in[ROOT_W-2:0], take};

        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_rem_reg[k]  <= rem_next;
                rad_root_reg[k] <= root_next;
            end
        end
    end

    // Round up when the remainder exceeds the floor root
    logic [ROOT_W:0]  rad_rnd;
    logic [RAD_W-1:0] rad_next;

    assign rad_rnd = (ROOT_W + 1)'(rad_root_reg[COORD_WIDTH+1])
                   + (ROOT_W + 1)'(rad_rem_reg[COORD_WIDTH+1]
                                   > REM_W'(rad_root_reg[COORD_WIDTH+1]));
    assign rad_next = (rad_rnd > (ROOT_W + 1)'(RAD_MAX)) ? RAD_W'(RAD_MAX)
                                                         : RAD_W'(rad_rnd);

    always_ff @(posedge aclk) begin
        if (adv) begin
            rad_val_reg[RAD_ST] <= rad_next;
        end
    end

    for (genvar k = RAD_ST + 1; k <= D - 2; k++) begin : g_rad_pipe
        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_val_reg[k] <= rad_val_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // First vectoring pass on (x, y): azimuth and xy magnitude
    // ------------------------------------------------------------------
    for (genvar k = 1; k <= N; k++) begin : g_pass1
        always_ff @(posedge aclk) begin
            if (adv) begin
                c1_reg[k] <= cordic_step(c1_reg[k-1], k - 1);
            end
        end
    end

    // Gain removal, high and low halves multiplied separately
    logic signed [DW-1:0]    gain_in;
    logic                    g_pos_next;
    logic [HI_PROD_W-1:0]    g_hi_reg;
    logic [LO_PROD_W-1:0]    g_lo_reg;
    logic                    g_pos_reg;
    logic signed [RND_W-1:0] phi_raw;
    logic signed [AZ_W-1:0]  phi_next;
    logic signed [AZ_W-1:0]  phi_reg [GAIN_ST:D-2];

    assign gain_in    = c1_reg[N].a;
    assign g_pos_next = !gain_in[DW-1] && (gain_in != '0);
    assign phi_raw    = acc_to_lsb(c1_reg[N].acc);

    always_comb begin
        if (phi_raw < AZ_MIN) begin
            phi_next = AZ_W'(AZ_MIN);
        end else if (phi_raw > AZ_MAX) begin
            phi_next = AZ_W'(AZ_MAX);
        end else begin
            phi_next = AZ_W'(phi_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g_hi_reg         <= HI_PROD_W'(gain_in[DW-1:LO_W]) * HI_PROD_W'(INV_GAIN);
            g_lo_reg         <= LO_PROD_W'(gain_in[LO_W-1:0]) * LO_PROD_W'(INV_GAIN);
            g_pos_reg        <= g_pos_next;
            phi_reg[GAIN_ST] <= phi_next;
        end
    end

    for (genvar k = GAIN_ST + 1; k <= D - 2; k++) begin : g_phi_pipe
        always_ff @(posedge aclk) begin
            if (adv) begin
                phi_reg[k] <= phi_reg[k-1];
            end
        end
    end

    logic [LO_PROD_W:0]    lo_rnd;
    logic [DW:0]           rho_sum;
    logic signed [DW-1:0]  rho_next;
    logic signed [DW-1:0]  rho_reg;

    assign lo_rnd   = (LO_PROD_W + 1)'(g_lo_reg) + (LO_PROD_W + 1)'(GAIN_HALF);
    assign rho_sum  = (DW + 1)'({g_hi_reg, {(LO_W - GAIN_FRAC){1'b0}}})
                    + (DW + 1)'(lo_rnd >> GAIN_FRAC);
    assign rho_next = g_pos_reg ? rho_sum[DW-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (adv) begin
            rho_reg <= rho_next;
        end
    end

    // ------------------------------------------------------------------
    // Second vectoring pass on (z, rho): polar angle
    // ------------------------------------------------------------------
    cordic_t c2_reg [PRE2_ST:PRE2_ST+N];

    always_ff @(posedge aclk) begin
        if (adv) begin
            c2_reg[PRE2_ST] <= cordic_start(scale_coord(z_reg[RHO_ST]), rho_reg);
        end
    end

    for (genvar k = PRE2_ST + 1; k <= PRE2_ST + N; k++) begin : g_pass2
        always_ff @(posedge aclk) begin
            if (adv) begin
                c2_reg[k] <= cordic_step(c2_reg[k-1], k - PRE2_ST - 1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage
    // ------------------------------------------------------------------
    logic signed [RND_W-1:0]  theta_raw;
    logic [POLAR_W-1:0]       theta_next;
    logic [POLAR_W-1:0]       pol_next;
    logic signed [AZ_W-1:0]   az_next;
    logic [RAD_W-1:0]         out_rad_reg;
    logic [POLAR_W-1:0]       out_pol_reg;
    logic signed [AZ_W-1:0]   out_az_reg;

    assign theta_raw = acc_to_lsb(c2_reg[PRE2_ST+N].acc);

    always_comb begin
        if (theta_raw < 0) begin
            theta_next = '0;
        end else if (theta_raw > POLAR_MAX) begin
            theta_next = POLAR_W'(POLAR_MAX);
        end else begin
            theta_next = POLAR_W'(theta_raw);
        end
    end

    // x = y = 0: angles come from the sign of z alone
    always_comb begin
        if (axis_reg[D-2]) begin
            pol_next = zneg_reg[D-2] ? POLAR_W'(POLAR_MAX) : '0;
            az_next  = '0;
        end else begin
            pol_next = theta_next;
            az_next  = phi_reg[D-2];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_rad_reg <= rad_val_reg[D-2];
            out_pol_reg <= pol_next;
            out_az_reg  <= az_next;
        end
    end

    assign pipe_word = OUT_TDATA_W'({out_az_reg, out_pol_reg, out_rad_reg});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic [RAD_W-1:0]   mt_rad;
    logic [POLAR_W-1:0] mt_pol;
    logic [AZ_W-1:0]    mt_az;

    assign mt_rad = m_tdata[RAD_W-1:0];
    assign mt_pol = m_tdata[RAD_W+POLAR_W-1:RAD_W];
    assign mt_az  = m_tdata[RAD_W+POLAR_W+AZ_W-1:RAD_W+POLAR_W];

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result presented straight after reset");

    a_polar_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (mt_pol <= POLAR_W'(POLAR_MAX)))
        else $error("polar angle beyond pi");

    a_az_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (($signed(mt_az) >= AZ_MIN) && ($signed(mt_az) <= AZ_MAX)))
        else $error("azimuth out of range");

    // Radius and angle lanes must stay aligned: zero radius is the origin
    a_origin_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (mt_rad == '0)) |-> ((mt_pol == '0) && (mt_az == '0)))
        else $error("radius and angles from different requests");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_valid_reg && !m_tready) |=> (hold_valid_reg && $stable(hold_word_reg)))
        else $error("skid register lost its result");

endmodule
